/* design/mnd3d_pkg.sv */
package mnd3d_pkg;

   // Field widths fixed by the interface.
   localparam int POS_W  = 6;
   localparam int VAL_W  = 8;
   localparam int THR_W  = 8;
   localparam int RAD_W  = 4;
   localparam int SIZE_W = 7;
   localparam int IDX_W  = 3;
   localparam int DATA_W = 8;

   // One memory word holds the mask voxel above the source voxel.
   localparam int WORD_W = 2 * VAL_W;

   // Request action codes.
   localparam logic ACT_WRITE = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   // Register reset values.
   localparam logic [THR_W-1:0]  THRESHOLD_RST = 8'd0;
   localparam logic [RAD_W-1:0]  RADIUS_RST    = 4'd1;
   localparam logic [SIZE_W-1:0] SIZE_RST      = 7'd64;

   // Configuration register indexes.
   typedef enum logic [IDX_W-1:0] {
      REG_THRESHOLD = 3'd0,
      REG_RADIUS    = 3'd1,
      REG_SIZE_X    = 3'd2,
      REG_SIZE_Y    = 3'd3,
      REG_SIZE_Z    = 3'd4
   } reg_index_type;

   // Query sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CENTER,
      ST_SCAN,
      ST_DRAIN
   } state_type;

endpackage

/* design/mnd3d_ram.sv */
module mnd3d_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 262144
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Single port: a write or a registered read in each cycle.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end else begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* design/masked_neighborhood_dilation_3d.sv */
// Channel    Handshake                    Payload
// request    start / busy                 req_action, req_pos_x/y/z, req_mask_value,
//                                         req_source_value
// response   rsp_strobe (one cycle)       rsp_out_value
// csr        csr_valid / csr_ready        csr_index, csr_wdata
//
// A write request leaves busy low, so requests can follow back to back.
// A query outside the volume answers with zero in the cycle after it is accepted.
// A query inside the volume holds busy while it makes one read of the center voxel and one
// read per neighbor on the single memory port, which sets the rate.
// The scan stops at the first mask voxel above the threshold.
// Reset is synchronous and clears the registers and the sequencer; the voxel memory is
// not cleared. The response cannot be stalled: rsp_strobe is high for exactly one cycle.
module masked_neighborhood_dilation_3d #(
   parameter int DIM_MAX    = 64,
   parameter int RADIUS_MAX = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_action,
   input  logic [mnd3d_pkg::POS_W-1:0]   req_pos_x,
   input  logic [mnd3d_pkg::POS_W-1:0]   req_pos_y,
   input  logic [mnd3d_pkg::POS_W-1:0]   req_pos_z,
   input  logic [mnd3d_pkg::VAL_W-1:0]   req_mask_value,
   input  logic [mnd3d_pkg::VAL_W-1:0]   req_source_value,
   output logic                          rsp_strobe,
   output logic [mnd3d_pkg::VAL_W-1:0]   rsp_out_value,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [mnd3d_pkg::IDX_W-1:0]   csr_index,
   input  logic [mnd3d_pkg::DATA_W-1:0]  csr_wdata
);

   localparam int DEPTH = DIM_MAX * DIM_MAX * DIM_MAX;
   localparam int AW    = $clog2(DEPTH);
   localparam int OFF_W = $clog2(RADIUS_MAX + 1) + 1;
   localparam int CRD_W = ((OFF_W > mnd3d_pkg::SIZE_W) ? OFF_W : mnd3d_pkg::SIZE_W) + 2;

   localparam int POS_W  = mnd3d_pkg::POS_W;
   localparam int VAL_W  = mnd3d_pkg::VAL_W;
   localparam int SIZE_W = mnd3d_pkg::SIZE_W;

   // Configuration registers.
   logic [mnd3d_pkg::THR_W-1:0] threshold_ff;
   logic [mnd3d_pkg::RAD_W-1:0] radius_ff;
   logic [SIZE_W-1:0]           size_x_ff;
   logic [SIZE_W-1:0]           size_y_ff;
   logic [SIZE_W-1:0]           size_z_ff;

   // Sequencer state.
   mnd3d_pkg::state_type    state_ff, state_in;
   logic [POS_W-1:0]        pos_x_ff, pos_x_in;
   logic [POS_W-1:0]        pos_y_ff, pos_y_in;
   logic [POS_W-1:0]        pos_z_ff, pos_z_in;
   logic signed [OFF_W-1:0] dx_ff, dx_in;
   logic signed [OFF_W-1:0] dy_ff, dy_in;
   logic signed [OFF_W-1:0] dz_ff, dz_in;
   logic                    rd_pend_ff, rd_pend_in;
   logic                    rd_center_ff, rd_center_in;
   logic [VAL_W-1:0]        src_ff, src_in;
   logic                    rsp_strobe_ff, rsp_strobe_in;
   logic [VAL_W-1:0]        rsp_value_ff, rsp_value_in;

   logic [SIZE_W-1:0]              n_x, n_y, n_z;
   logic signed [OFF_W-1:0]        r_eff;
   logic signed [OFF_W-1:0]        r_neg;
   logic                           req_accept;
   logic                           req_inside;
   logic                           scan_last;
   logic                           hit;
   logic [VAL_W-1:0]               hit_value;
   logic [SIZE_W-1:0]              cx, cy, cz;
   logic                           ram_we;
   logic [AW-1:0]                  ram_addr;
   logic [mnd3d_pkg::WORD_W-1:0]   ram_wdata;
   logic [mnd3d_pkg::WORD_W-1:0]   ram_rdata;

   // Clamp a neighbor coordinate to the volume edges.
   function automatic logic [SIZE_W-1:0] clamp_coord(input logic [POS_W-1:0]        p,
                                                     input logic signed [OFF_W-1:0] d,
                                                     input logic [SIZE_W-1:0]       n);
      logic signed [CRD_W-1:0] c;
      logic signed [CRD_W-1:0] lim;
      logic [SIZE_W-1:0]       res;
      c   = signed'(CRD_W'(p)) + CRD_W'(d);
      lim = signed'(CRD_W'(n));
      if (c < 0) begin
         res = '0;
      end else if (c >= lim) begin
         res = n - SIZE_W'(1);
      end else begin
         res = c[SIZE_W-1:0];
      end
      return res;
   endfunction

   // Linear memory address of a voxel.
   function automatic logic [AW-1:0] addr_of(input logic [SIZE_W-1:0] x,
                                             input logic [SIZE_W-1:0] y,
                                             input logic [SIZE_W-1:0] z);
      return (AW'(z) * AW'(DIM_MAX) + AW'(y)) * AW'(DIM_MAX) + AW'(x);
   endfunction

   // Effective sizes: zero acts as one, anything above the memory extent is capped.
   function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
      logic [SIZE_W-1:0] res;
      if (s == '0) begin
         res = SIZE_W'(1);
      end else if (32'(s) > DIM_MAX) begin
         res = SIZE_W'(DIM_MAX);
      end else begin
         res = s;
      end
      return res;
   endfunction

   assign n_x   = eff_size(size_x_ff);
   assign n_y   = eff_size(size_y_ff);
   assign n_z   = eff_size(size_z_ff);
   assign r_eff = (32'(radius_ff) > RADIUS_MAX) ? OFF_W'(RADIUS_MAX) : OFF_W'(radius_ff);
   assign r_neg = -r_eff;

   // Configuration writes; unknown indexes are dropped.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= mnd3d_pkg::THRESHOLD_RST;
         radius_ff    <= mnd3d_pkg::RADIUS_RST;
         size_x_ff    <= mnd3d_pkg::SIZE_RST;
         size_y_ff    <= mnd3d_pkg::SIZE_RST;
         size_z_ff    <= mnd3d_pkg::SIZE_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            mnd3d_pkg::REG_THRESHOLD: threshold_ff <= csr_wdata[mnd3d_pkg::THR_W-1:0];
            mnd3d_pkg::REG_RADIUS:    radius_ff    <= csr_wdata[mnd3d_pkg::RAD_W-1:0];
            mnd3d_pkg::REG_SIZE_X:    size_x_ff    <= csr_wdata[SIZE_W-1:0];
            mnd3d_pkg::REG_SIZE_Y:    size_y_ff    <= csr_wdata[SIZE_W-1:0];
            mnd3d_pkg::REG_SIZE_Z:    size_z_ff    <= csr_wdata[SIZE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Request decode.
   assign busy       = (state_ff != mnd3d_pkg::ST_IDLE);
   assign req_accept = start && !busy;
   assign req_inside = (SIZE_W'(req_pos_x) < n_x) && (SIZE_W'(req_pos_y) < n_y)
                       && (SIZE_W'(req_pos_z) < n_z);

   // Neighbor coordinates for the current scan offset.
   assign cx = clamp_coord(pos_x_ff, dx_ff, n_x);
   assign cy = clamp_coord(pos_y_ff, dy_ff, n_y);
   assign cz = clamp_coord(pos_z_ff, dz_ff, n_z);

   // Memory port: writes come straight from an accepted request, reads from the sequencer.
   assign ram_we    = req_accept && (req_action == mnd3d_pkg::ACT_WRITE) && req_inside;
   assign ram_wdata = {req_mask_value, req_source_value};

   always_comb begin
      case (state_ff)
         mnd3d_pkg::ST_IDLE:
            ram_addr = addr_of(SIZE_W'(req_pos_x), SIZE_W'(req_pos_y), SIZE_W'(req_pos_z));
         mnd3d_pkg::ST_CENTER:
            ram_addr = addr_of(SIZE_W'(pos_x_ff), SIZE_W'(pos_y_ff), SIZE_W'(pos_z_ff));
         default:
            ram_addr = addr_of(cx, cy, cz);
      endcase
   end

   mnd3d_ram #(
      .WIDTH (mnd3d_pkg::WORD_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // Returned read data: any mask voxel above the threshold ends the scan.
   assign hit       = rd_pend_ff && (ram_rdata[mnd3d_pkg::WORD_W-1:VAL_W] > threshold_ff);
   assign hit_value = rd_center_ff ? ram_rdata[VAL_W-1:0] : src_ff;
   assign scan_last = (dx_ff == r_eff) && (dy_ff == r_eff) && (dz_ff == r_eff);

   // Sequencer next state.
   always_comb begin
      state_in      = state_ff;
      pos_x_in      = pos_x_ff;
      pos_y_in      = pos_y_ff;
      pos_z_in      = pos_z_ff;
      dx_in         = dx_ff;
      dy_in         = dy_ff;
      dz_in         = dz_ff;
      rd_pend_in    = 1'b0;
      rd_center_in  = 1'b0;
      src_in        = (rd_pend_ff && rd_center_ff) ? ram_rdata[VAL_W-1:0] : src_ff;
      rsp_strobe_in = 1'b0;
      rsp_value_in  = rsp_value_ff;

      case (state_ff)
         mnd3d_pkg::ST_IDLE: begin
            if (req_accept && (req_action == mnd3d_pkg::ACT_QUERY)) begin
               if (req_inside) begin
                  pos_x_in = req_pos_x;
                  pos_y_in = req_pos_y;
                  pos_z_in = req_pos_z;
                  dx_in    = r_neg;
                  dy_in    = r_neg;
                  dz_in    = r_neg;
                  state_in = mnd3d_pkg::ST_CENTER;
               end else begin
                  rsp_strobe_in = 1'b1;
                  rsp_value_in  = '0;
               end
            end
         end

         mnd3d_pkg::ST_CENTER: begin
            rd_pend_in   = 1'b1;
            rd_center_in = 1'b1;
            state_in     = mnd3d_pkg::ST_SCAN;
         end

         mnd3d_pkg::ST_SCAN: begin
            if (hit) begin
               rsp_strobe_in = 1'b1;
               rsp_value_in  = hit_value;
               state_in      = mnd3d_pkg::ST_IDLE;
            end else begin
               rd_pend_in = 1'b1;
               if (dx_ff != r_eff) begin
                  dx_in = dx_ff + OFF_W'(1);
               end else begin
                  dx_in = r_neg;
                  if (dy_ff != r_eff) begin
                     dy_in = dy_ff + OFF_W'(1);
                  end else begin
                     dy_in = r_neg;
                     dz_in = dz_ff + OFF_W'(1);
                  end
               end
               if (scan_last) begin
                  state_in = mnd3d_pkg::ST_DRAIN;
               end
            end
         end

         mnd3d_pkg::ST_DRAIN: begin
            rsp_strobe_in = 1'b1;
            rsp_value_in  = hit ? hit_value : '0;
            state_in      = mnd3d_pkg::ST_IDLE;
         end

         default: begin
            state_in = mnd3d_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= mnd3d_pkg::ST_IDLE;
         rd_pend_ff    <= 1'b0;
         rd_center_ff  <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rd_pend_ff    <= rd_pend_in;
         rd_center_ff  <= rd_center_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      pos_x_ff     <= pos_x_in;
      pos_y_ff     <= pos_y_in;
      pos_z_ff     <= pos_z_in;
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      dz_ff        <= dz_in;
      src_ff       <= src_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_out_value = rsp_value_ff;

   // A response is only ever given once the sequencer is back in idle.
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("response while a query is still scanning");

   // A query outside the volume answers zero in the next cycle.
   a_outside_zero: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_action == mnd3d_pkg::ACT_QUERY) && !req_inside)
      |=> (rsp_strobe && (rsp_out_value == '0)))
      else $error("outside query did not answer zero");

   // A query inside the volume starts a scan.
   a_inside_scan: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_action == mnd3d_pkg::ACT_QUERY) && req_inside)
      |=> (state_ff == mnd3d_pkg::ST_CENTER))
      else $error("inside query did not start a scan");

   // The memory is written only while no scan is reading it.
   a_write_idle: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == mnd3d_pkg::ST_IDLE))
      else $error("voxel write during a scan");

   // Read data tagged as center data follows the center read state.
   a_center_tag: assert property (@(posedge clock) disable iff (reset)
      rd_center_ff |-> ($past(state_ff) == mnd3d_pkg::ST_CENTER) && rd_pend_ff)
      else $error("center read tag out of step");

endmodule

/* sim/tb_top.sv */
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int POS_W  = mnd3d_pkg::POS_W;
   localparam int VAL_W  = mnd3d_pkg::VAL_W;
   localparam int THR_W  = mnd3d_pkg::THR_W;
   localparam int RAD_W  = mnd3d_pkg::RAD_W;
   localparam int SIZE_W = mnd3d_pkg::SIZE_W;
   localparam int IDX_W  = mnd3d_pkg::IDX_W;
   localparam int DATA_W = mnd3d_pkg::DATA_W;

   localparam int DIM           = 64;
   localparam int RADIUS_LIMIT  = 8;
   localparam int VOXELS        = DIM * DIM * DIM;
   localparam int RESET_CYCLES  = 4;
   localparam int SETTLE_CYCLES = 8;
   localparam int CYCLE_LIMIT   = 3_000_000;
   localparam int RANDOM_PHASES = 12;

   // Register indexes that the block does not implement.
   localparam logic [IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
   localparam logic [IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

   logic               clock            = 1'b0;
   logic               reset            = 1'b1;
   logic               start            = 1'b0;
   logic               busy;
   logic               req_action       = mnd3d_pkg::ACT_WRITE;
   logic [POS_W-1:0]   req_pos_x        = '0;
   logic [POS_W-1:0]   req_pos_y        = '0;
   logic [POS_W-1:0]   req_pos_z        = '0;
   logic [VAL_W-1:0]   req_mask_value   = '0;
   logic [VAL_W-1:0]   req_source_value = '0;
   logic               rsp_strobe;
   logic [VAL_W-1:0]   rsp_out_value;
   logic               csr_valid        = 1'b0;
   logic               csr_ready;
   logic [IDX_W-1:0]   csr_index        = '0;
   logic [DATA_W-1:0]  csr_wdata        = '0;

   // Shadow copy of the register file.
   logic [THR_W-1:0]   threshold_q = mnd3d_pkg::THRESHOLD_RST;
   logic [RAD_W-1:0]   radius_q    = mnd3d_pkg::RADIUS_RST;
   logic [SIZE_W-1:0]  size_x_q    = mnd3d_pkg::SIZE_RST;
   logic [SIZE_W-1:0]  size_y_q    = mnd3d_pkg::SIZE_RST;
   logic [SIZE_W-1:0]  size_z_q    = mnd3d_pkg::SIZE_RST;

   // Shadow copy of the voxel volumes and which voxels hold data.
   logic [VAL_W-1:0]   mask_volume   [VOXELS];
   logic [VAL_W-1:0]   source_volume [VOXELS];
   bit                 voxel_written [VOXELS];

   // Dilated values still owed by the block, oldest first.
   logic [VAL_W-1:0]   owed_out_values [$];

   bit gaps_off = 1'b0;
   int hot_pct  = 10;

   int cycle_count    = 0;
   int mismatch_count = 0;
   int query_count    = 0;
   int write_count    = 0;
   int response_count = 0;
   int setting_count  = 0;

   masked_neighborhood_dilation_3d dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_action       (req_action),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_pos_z        (req_pos_z),
      .req_mask_value   (req_mask_value),
      .req_source_value (req_source_value),
      .rsp_strobe       (rsp_strobe),
      .rsp_out_value    (rsp_out_value),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #6 clock = ~clock;

   // A size of zero behaves as one voxel, anything above the maximum as the maximum.
   function automatic int extent(logic [SIZE_W-1:0] s);
      if (s == 0) return 1;
      if (s > DIM) return DIM;
      return int'(s);
   endfunction

   function automatic int voxel_addr(int x, int y, int z);
      return (z * DIM + y) * DIM + x;
   endfunction

   function automatic int clamp_axis(int c, int n);
      if (c < 0) return 0;
      if (c >= n) return n - 1;
      return c;
   endfunction

   function automatic bit inside_volume(int x, int y, int z);
      return x < extent(size_x_q) && y < extent(size_y_q) && z < extent(size_z_q);
   endfunction

   function automatic int scan_radius();
      return (radius_q > RADIUS_LIMIT) ? RADIUS_LIMIT : int'(radius_q);
   endfunction

   // The source voxel if any mask voxel of the clamped cube exceeds the threshold, else zero.
   function automatic logic [VAL_W-1:0] dilated_value(int x, int y, int z);
      int r;
      int xi;
      int yi;
      int zi;
      if (!inside_volume(x, y, z)) return '0;
      r = scan_radius();
      for (int dz = -r; dz <= r; dz++) begin
         zi = clamp_axis(z + dz, extent(size_z_q));
         for (int dy = -r; dy <= r; dy++) begin
            yi = clamp_axis(y + dy, extent(size_y_q));
            for (int dx = -r; dx <= r; dx++) begin
               xi = clamp_axis(x + dx, extent(size_x_q));
               if (mask_volume[voxel_addr(xi, yi, zi)] > threshold_q)
                  return source_volume[voxel_addr(x, y, z)];
            end
         end
      end
      return '0;
   endfunction

   // Mostly no pause or a short one, some medium and a rare long one.
   function automatic int pick_gap();
      int roll;
      if (gaps_off) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Most mask voxels sit at or below the threshold so that both outcomes occur.
   function automatic logic [VAL_W-1:0] pick_mask();
      if ($urandom_range(0, 99) < hot_pct) return VAL_W'($urandom_range(0, 255));
      return VAL_W'($urandom_range(0, threshold_q));
   endfunction

   // Coordinates inside an axis of n voxels, biased toward the two faces.
   function automatic int pick_coord(int n);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 12) return 0;
      if (roll < 25) return n - 1;
      return $urandom_range(0, n - 1);
   endfunction

   // Small raw size values, including zero, so that the filled region stays compact.
   function automatic int pick_size();
      if ($urandom_range(0, 99) < 10) return 0;
      return $urandom_range(1, 6);
   endfunction

   task automatic report_mismatch(input string msg);
      $display("ERROR cycle %0d: %s", cycle_count, msg);
      mismatch_count++;
   endtask

   // Send one request and update the shadow state once it is accepted.
   task automatic send_request(input logic action, input int x, input int y, input int z,
                               input logic [VAL_W-1:0] mask_v,
                               input logic [VAL_W-1:0] source_v);
      int gap;
      int addr;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start            <= 1'b1;
      req_action       <= action;
      req_pos_x        <= x[POS_W-1:0];
      req_pos_y        <= y[POS_W-1:0];
      req_pos_z        <= z[POS_W-1:0];
      req_mask_value   <= mask_v;
      req_source_value <= source_v;
      do @(posedge clock); while (busy);
      if (action == mnd3d_pkg::ACT_QUERY) begin
         owed_out_values.push_back(dilated_value(x, y, z));
         query_count++;
      end else begin
         write_count++;
         if (inside_volume(x, y, z)) begin
            addr = voxel_addr(x, y, z);
            mask_volume[addr]   = mask_v;
            source_volume[addr] = source_v;
            voxel_written[addr] = 1'b1;
         end
      end
   endtask

   // Write every voxel that a query at this position could read and that holds no data yet.
   task automatic fill_neighborhood(input int x, input int y, input int z);
      int r;
      int xi;
      int yi;
      int zi;
      r = scan_radius();
      for (int dz = -r; dz <= r; dz++) begin
         for (int dy = -r; dy <= r; dy++) begin
            for (int dx = -r; dx <= r; dx++) begin
               xi = clamp_axis(x + dx, extent(size_x_q));
               yi = clamp_axis(y + dy, extent(size_y_q));
               zi = clamp_axis(z + dz, extent(size_z_q));
               if (!voxel_written[voxel_addr(xi, yi, zi)])
                  send_request(mnd3d_pkg::ACT_WRITE, xi, yi, zi, pick_mask(),
                               VAL_W'($urandom_range(0, 255)));
            end
         end
      end
   endtask

   task automatic query_voxel(input int x, input int y, input int z);
      if (inside_volume(x, y, z)) fill_neighborhood(x, y, z);
      send_request(mnd3d_pkg::ACT_QUERY, x, y, z, VAL_W'($urandom_range(0, 255)),
                   VAL_W'($urandom_range(0, 255)));
   endtask

   // Wait until every owed result has come and the block has had time to settle.
   task automatic wait_until_quiet();
      start <= 1'b0;
      while (owed_out_values.size() != 0 || busy) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register writes only happen with the block idle.
   task automatic write_register(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
      wait_until_quiet();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         mnd3d_pkg::REG_THRESHOLD: threshold_q = data[THR_W-1:0];
         mnd3d_pkg::REG_RADIUS:    radius_q    = data[RAD_W-1:0];
         mnd3d_pkg::REG_SIZE_X:    size_x_q    = data[SIZE_W-1:0];
         mnd3d_pkg::REG_SIZE_Y:    size_y_q    = data[SIZE_W-1:0];
         mnd3d_pkg::REG_SIZE_Z:    size_z_q    = data[SIZE_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic configure(input int thr, input int rad, input int sx, input int sy,
                            input int sz);
      write_register(mnd3d_pkg::REG_THRESHOLD, DATA_W'(thr));
      write_register(mnd3d_pkg::REG_RADIUS, DATA_W'(rad));
      write_register(mnd3d_pkg::REG_SIZE_X, DATA_W'(sx));
      write_register(mnd3d_pkg::REG_SIZE_Y, DATA_W'(sy));
      write_register(mnd3d_pkg::REG_SIZE_Z, DATA_W'(sz));
      setting_count++;
   endtask

   // Queries at corners and in the middle with the settings left by reset.
   task automatic test_reset_defaults();
      query_voxel(0, 0, 0);
      query_voxel(DIM - 1, DIM - 1, DIM - 1);
      query_voxel(31, 32, 33);
   endtask

   // A mask equal to the threshold must not count; one above it must.
   task automatic test_threshold_extremes();
      write_register(mnd3d_pkg::REG_RADIUS, 8'd0);
      send_request(mnd3d_pkg::ACT_WRITE, 10, 10, 10, 8'h00, 8'hA5);
      query_voxel(10, 10, 10);
      send_request(mnd3d_pkg::ACT_WRITE, 10, 10, 10, 8'h01, 8'hA5);
      query_voxel(10, 10, 10);
      write_register(mnd3d_pkg::REG_THRESHOLD, 8'hFF);
      send_request(mnd3d_pkg::ACT_WRITE, 10, 10, 10, 8'hFF, 8'hFF);
      query_voxel(10, 10, 10);
      write_register(mnd3d_pkg::REG_THRESHOLD, 8'hFE);
      query_voxel(10, 10, 10);
      write_register(mnd3d_pkg::REG_THRESHOLD, 8'h00);
   endtask

   // Radius above the maximum, clamping at the faces, and sizes of zero or past the maximum.
   task automatic test_radius_and_size();
      write_register(mnd3d_pkg::REG_SIZE_X, 8'd4);
      write_register(mnd3d_pkg::REG_SIZE_Y, 8'd4);
      write_register(mnd3d_pkg::REG_SIZE_Z, 8'd4);
      write_register(mnd3d_pkg::REG_RADIUS, 8'h0F);
      for (int z = 0; z < 4; z++)
         for (int y = 0; y < 4; y++)
            for (int x = 0; x < 4; x++)
               send_request(mnd3d_pkg::ACT_WRITE, x, y, z, 8'h00,
                            VAL_W'($urandom_range(0, 255)));
      send_request(mnd3d_pkg::ACT_WRITE, 3, 3, 3, 8'hC8, 8'h5A);
      query_voxel(0, 0, 0);
      write_register(mnd3d_pkg::REG_THRESHOLD, 8'hC8);
      query_voxel(0, 0, 0);
      write_register(mnd3d_pkg::REG_THRESHOLD, 8'h00);
      // Upper data bits are dropped, leaving radius one.
      write_register(mnd3d_pkg::REG_RADIUS, 8'hF1);
      query_voxel(0, 0, 0);
      query_voxel(2, 2, 2);
      write_register(mnd3d_pkg::REG_SIZE_X, 8'd0);
      write_register(mnd3d_pkg::REG_SIZE_Y, 8'd0);
      write_register(mnd3d_pkg::REG_SIZE_Z, 8'd0);
      query_voxel(0, 0, 0);
      query_voxel(1, 0, 0);
      write_register(mnd3d_pkg::REG_SIZE_X, 8'hC8);
      write_register(mnd3d_pkg::REG_SIZE_Y, 8'h7F);
      write_register(mnd3d_pkg::REG_SIZE_Z, 8'd100);
      query_voxel(DIM - 1, 0, 0);
   endtask

   // Writes outside the volume are dropped and resizing keeps stored voxels in place.
   task automatic test_outside_volume();
      write_register(mnd3d_pkg::REG_RADIUS, 8'd0);
      send_request(mnd3d_pkg::ACT_WRITE, 5, 6, 7, 8'hFF, 8'h3C);
      write_register(mnd3d_pkg::REG_SIZE_X, 8'd4);
      send_request(mnd3d_pkg::ACT_WRITE, 5, 6, 7, 8'h00, 8'h00);
      query_voxel(5, 6, 7);
      write_register(mnd3d_pkg::REG_SIZE_X, 8'd64);
      write_register(mnd3d_pkg::REG_SIZE_Y, 8'd6);
      send_request(mnd3d_pkg::ACT_WRITE, 5, 6, 7, 8'h00, 8'h00);
      query_voxel(5, 6, 7);
      write_register(mnd3d_pkg::REG_SIZE_Y, 8'd64);
      write_register(mnd3d_pkg::REG_SIZE_Z, 8'd7);
      send_request(mnd3d_pkg::ACT_WRITE, 5, 6, 7, 8'h00, 8'h00);
      query_voxel(5, 6, 7);
      write_register(mnd3d_pkg::REG_SIZE_Z, 8'd64);
      query_voxel(5, 6, 7);
   endtask

   // Writes to unimplemented indexes must leave every setting alone.
   task automatic test_unknown_register();
      for (int i = REG_SPARE_FIRST; i <= REG_SPARE_LAST; i++)
         write_register(IDX_W'(i), DATA_W'($urandom_range(0, 255)));
      query_voxel(5, 6, 7);
      query_voxel(10, 10, 10);
   endtask

   // One random request: mostly inside the volume, some anywhere in the address space.
   task automatic random_request();
      int x;
      int y;
      int z;
      if ($urandom_range(0, 99) < 15) begin
         x = $urandom_range(0, DIM - 1);
         y = $urandom_range(0, DIM - 1);
         z = $urandom_range(0, DIM - 1);
      end else begin
         x = pick_coord(extent(size_x_q));
         y = pick_coord(extent(size_y_q));
         z = pick_coord(extent(size_z_q));
      end
      if ($urandom_range(0, 99) < 45)
         query_voxel(x, y, z);
      else
         send_request(mnd3d_pkg::ACT_WRITE, x, y, z, pick_mask(),
                      VAL_W'($urandom_range(0, 255)));
   endtask

   // Random traffic under a series of settings; large radii only on small volumes.
   // The full volume gets only a few requests since each query there fills its cube first.
   task automatic test_random_traffic();
      int thr;
      int rad;
      int sx;
      int sy;
      int sz;
      int items;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         hot_pct  = $urandom_range(2, 30);
         gaps_off = (phase % 4 == 3);
         items    = 20;
         thr      = $urandom_range(0, 255);
         case (phase)
            0: begin
               thr   = 0;
               rad   = 1;
               sx    = DIM;
               sy    = DIM;
               sz    = DIM;
               items = 8;
            end
            1: begin
               thr   = 255;
               rad   = 0;
               sx    = 1;
               sy    = 2;
               sz    = DIM;
               items = 25;
            end
            2, 3: begin
               rad   = (phase == 2) ? RADIUS_LIMIT : 15;
               sx    = $urandom_range(1, 4);
               sy    = $urandom_range(1, 4);
               sz    = $urandom_range(1, 4);
               items = 15;
            end
            default: begin
               rad = $urandom_range(0, 2);
               sx  = pick_size();
               sy  = pick_size();
               sz  = pick_size();
            end
         endcase
         configure(thr, rad, sx, sy, sz);
         repeat (items) random_request();
      end
      gaps_off = 1'b0;
   endtask

   task automatic finish_run();
      wait_until_quiet();
      $display("Sent %0d requests (%0d queries, %0d voxel writes) under %0d random settings",
               query_count + write_count, query_count, write_count, setting_count);
      $display("plus directed cases; %0d responses checked, %0d mismatches.",
               response_count, mismatch_count);
      if (mismatch_count == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   endtask

   // Compare each response with the oldest owed value.
   always @(posedge clock) begin : check_responses
      logic [VAL_W-1:0] want;
      if (!reset && rsp_strobe) begin
         response_count++;
         if (owed_out_values.size() == 0) begin
            report_mismatch($sformatf("response %0h with no request owed", rsp_out_value));
         end else begin
            want = owed_out_values.pop_front();
            if (rsp_out_value !== want)
               report_mismatch($sformatf("out_value %0h, expected %0h", rsp_out_value, want));
         end
      end
   end

   // Hard stop in case the block hangs or loses a response.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d responses still owed.",
                  cycle_count, owed_out_values.size());
         $display("tb_top NOT OK");
         $finish;
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_threshold_extremes();
      test_radius_and_size();
      test_outside_volume();
      test_unknown_register();
      test_random_traffic();
      finish_run();
   end

endmodule
